FILE: rtl/core/pli_pkg.sv
package pli_pkg;

    // value format: signed fixed point, 16 fraction bits
    localparam int VW      = 48;          // value width
    localparam int MW      = VW + 1;      // magnitude of a difference
    localparam int AW      = VW + 3;      // shared adder width
    localparam int CNT_W   = $clog2(MW);  // step counter for mul / div
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] RANGE_IN    = 2'd0;
    localparam logic [1:0] RANGE_BELOW = 2'd1;
    localparam logic [1:0] RANGE_ABOVE = 2'd2;

    // register index is paddr[2] (word address)
    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic [CFG_W-1:0] POINT_COUNT_RST = 7'd64;

    localparam logic [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic                 op;
        logic [IDX_W-1:0]     point_index;
        logic signed [VW-1:0] x_value;
        logic signed [VW-1:0] y_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0] y_result;
        logic [1:0]           range_flag;
        logic                 zero_width;
    } t_out_item;

    typedef struct packed {
        logic [AW-1:0] sum;
        logic          neg;
    } t_alu_res;

    function automatic logic [AW-1:0] sext_v(input logic [VW-1:0] v);
        return {{(AW-VW){v[VW-1]}}, v};
    endfunction

    function automatic logic [AW-1:0] zext_m(input logic [MW-1:0] v);
        return {{(AW-MW){1'b0}}, v};
    endfunction

endpackage

FILE: rtl/core/pli_ram.sv
module pli_ram
    #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
    )
    (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/pli_alu.sv
module pli_alu
    import pli_pkg::*;
    (
    input  logic [AW-1:0] i_a,
    input  logic [AW-1:0] i_b,
    input  logic          i_sub,
    output t_alu_res      o_res
    );

    logic [AW-1:0] b_eff;
    logic [AW-1:0] sum;

    assign b_eff = i_sub ? ~i_b : i_b;
    assign sum   = i_a + b_eff + AW'(i_sub);

    assign o_res.sum = sum;
    assign o_res.neg = sum[AW-1];

endmodule

FILE: rtl/core/piecewise_linear_interpolator.sv
// Channel   Dir  Handshake                      Beat
// in        in   i_in_valid / o_in_ready        t_in_item  (load or evaluate)
// out       out  o_out_valid / i_out_ready      t_out_item (one per input beat)
// cfg       in   APB psel/penable/pwrite        point_count at byte address 0
//
// Load: the entry is written on accept, then the result register is loaded. Evaluate:
// range checks on the first and last points, a linear search when in range, the segment
// ends read, the differences, the 49-step shift-add multiply and 49-step restoring divide
// on the one shared adder, and the final add; a zero-width segment ends after the first
// difference step, and an oversized quotient skips the divide. Reset clears the sequencer,
// the output valid flag and point_count (64), not the table. o_in_ready is high only idle.
module piecewise_linear_interpolator
    import pli_pkg::*;
    #(
    parameter int MAX_POINTS = 64
    )
    (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
    );

    localparam int IW = $clog2(MAX_POINTS);
    localparam logic [IW-1:0] LAST_MAX = IW'(MAX_POINTS - 1);

    localparam logic [1:0] DSEL_DX = 2'd0;
    localparam logic [1:0] DSEL_DY = 2'd1;
    localparam logic [1:0] DSEL_DQ = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_LO,
        S_CHK_HI,
        S_SRCH,
        S_LD_A,
        S_LD_B,
        S_DIFF,
        S_ABS,
        S_MUL,
        S_DCHK,
        S_DIV,
        S_ADD,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [VW-1:0]     r_x, n_x;
    logic [IW-1:0]     r_last, n_last;
    logic [IW-1:0]     r_i, n_i;
    logic [IW-1:0]     r_s, n_s;
    logic [1:0]        r_flag, n_flag;
    logic [VW-1:0]     r_x0, n_x0;
    logic [VW-1:0]     r_y0, n_y0;
    logic [VW-1:0]     r_x1, n_x1;
    logic [VW-1:0]     r_y1, n_y1;
    logic [1:0]        r_dsel, n_dsel;
    logic [AW-1:0]     r_acc, n_acc;
    logic              r_neg, n_neg;
    logic [MW-1:0]     r_div, n_div;
    logic [MW-1:0]     r_mcand, n_mcand;
    logic [MW-1:0]     r_hi, n_hi;
    logic [MW-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic [VW-1:0]     r_res, n_res;
    logic              r_zw, n_zw;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;
    logic [CFG_W-1:0]  r_point_count, n_point_count;

    logic [AW-1:0]     alu_a, alu_b;
    logic              alu_sub;
    t_alu_res          alu;

    logic              ram_we;
    logic [IW-1:0]     ram_addr;
    logic [2*VW-1:0]   ram_rdata;
    logic [VW-1:0]     rd_x, rd_y;

    logic [31:0]       idx_w;
    logic [31:0]       cnt_w;
    logic [IW-1:0]     last_idx;
    logic [MW-1:0]     mag;
    logic              cfg_wr;

    pli_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu)
    );

    pli_ram #(
        .WIDTH (2 * VW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_in_data.x_value, i_in_data.y_value}),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[2*VW-1:VW];
    assign rd_y = ram_rdata[VW-1:0];

    assign idx_w = 32'(i_in_data.point_index);
    assign cnt_w = 32'(r_point_count);
    assign mag   = alu.sum[MW-1:0];

    // point_count clamped to 2 .. MAX_POINTS, kept as index of last entry
    always_comb begin
        if (cnt_w < 32'd2) begin
            last_idx = IW'(1);
        end else if (cnt_w > 32'(MAX_POINTS)) begin
            last_idx = LAST_MAX;
        end else begin
            last_idx = IW'(cnt_w - 32'd1);
        end
    end

    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_POINT_COUNT);
    assign prdata = (paddr[2] == REG_POINT_COUNT) ?
                    {{(PDATA_W-CFG_W){1'b0}}, r_point_count} : '0;
    assign pready = 1'b1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state       = r_state;
        n_x           = r_x;
        n_last        = r_last;
        n_i           = r_i;
        n_s           = r_s;
        n_flag        = r_flag;
        n_x0          = r_x0;
        n_y0          = r_y0;
        n_x1          = r_x1;
        n_y1          = r_y1;
        n_dsel        = r_dsel;
        n_acc         = r_acc;
        n_neg         = r_neg;
        n_div         = r_div;
        n_mcand       = r_mcand;
        n_hi          = r_hi;
        n_lo          = r_lo;
        n_cnt         = r_cnt;
        n_ovf         = r_ovf;
        n_res         = r_res;
        n_zw          = r_zw;
        n_out_valid   = r_out_valid & ~i_out_ready;
        n_out_data    = r_out_data;
        n_point_count = cfg_wr ? pwdata[CFG_W-1:0] : r_point_count;
        alu_a         = '0;
        alu_b         = '0;
        alu_sub       = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = r_s;

        unique case (r_state)
            S_IDLE: begin
                ram_addr = (i_in_data.op == OP_LOAD) ? idx_w[IW-1:0] : '0;
                if (i_in_valid) begin
                    n_flag = RANGE_IN;
                    n_zw   = 1'b0;
                    n_res  = '0;
                    if (i_in_data.op == OP_LOAD) begin
                        ram_we  = (idx_w < 32'(MAX_POINTS));
                        n_state = S_DONE;
                    end else begin
                        n_x     = i_in_data.x_value;
                        n_last  = last_idx;
                        n_neg   = 1'b0;
                        n_ovf   = 1'b0;
                        n_state = S_CHK_LO;
                    end
                end
            end
            S_CHK_LO: begin
                // x < x[0] ?
                alu_a   = sext_v(r_x);
                alu_b   = sext_v(rd_x);
                alu_sub = 1'b1;
                if (alu.neg) begin
                    n_flag   = RANGE_BELOW;
                    n_s      = '0;
                    ram_addr = '0;
                    n_state  = S_LD_A;
                end else begin
                    ram_addr = r_last;
                    n_state  = S_CHK_HI;
                end
            end
            S_CHK_HI: begin
                // x[last] < x ?
                alu_a   = sext_v(rd_x);
                alu_b   = sext_v(r_x);
                alu_sub = 1'b1;
                if (alu.neg) begin
                    n_flag   = RANGE_ABOVE;
                    n_s      = r_last - 1'b1;
                    ram_addr = r_last - 1'b1;
                    n_state  = S_LD_A;
                end else begin
                    n_i      = '0;
                    ram_addr = IW'(1);
                    n_state  = S_SRCH;
                end
            end
            S_SRCH: begin
                // rd_x holds x[i+1]; stop at first one not below x, or at the last segment
                alu_a   = sext_v(rd_x);
                alu_b   = sext_v(r_x);
                alu_sub = 1'b1;
                if (!alu.neg || (r_i + 1'b1 == r_last)) begin
                    n_s      = r_i;
                    ram_addr = r_i;
                    n_state  = S_LD_A;
                end else begin
                    n_i      = r_i + 1'b1;
                    ram_addr = r_i + IW'(2);
                end
            end
            S_LD_A: begin
                n_x0     = rd_x;
                n_y0     = rd_y;
                ram_addr = r_s + 1'b1;
                n_state  = S_LD_B;
            end
            S_LD_B: begin
                n_x1    = rd_x;
                n_y1    = rd_y;
                n_dsel  = DSEL_DX;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                alu_sub = 1'b1;
                case (r_dsel)
                    DSEL_DX: begin
                        alu_a = sext_v(r_x1);
                        alu_b = sext_v(r_x0);
                    end
                    DSEL_DY: begin
                        alu_a = sext_v(r_y1);
                        alu_b = sext_v(r_y0);
                    end
                    default: begin
                        alu_a = sext_v(r_x);
                        alu_b = sext_v(r_x0);
                    end
                endcase
                n_acc   = alu.sum;
                n_state = S_ABS;
            end
            S_ABS: begin
                // 0 - acc when negative, else acc
                alu_a   = '0;
                alu_b   = r_acc;
                alu_sub = r_acc[AW-1];
                n_neg   = r_neg ^ r_acc[AW-1];
                case (r_dsel)
                    DSEL_DX: begin
                        n_div = mag;
                        if (r_acc == '0) begin
                            n_zw    = 1'b1;
                            n_res   = r_y0;
                            n_state = S_DONE;
                        end else begin
                            n_dsel  = DSEL_DY;
                            n_state = S_DIFF;
                        end
                    end
                    DSEL_DY: begin
                        n_mcand = mag;
                        n_dsel  = DSEL_DQ;
                        n_state = S_DIFF;
                    end
                    default: begin
                        n_lo    = mag;
                        n_hi    = '0;
                        n_cnt   = '0;
                        n_state = S_MUL;
                    end
                endcase
            end
            S_MUL: begin
                // shift-add, product ends in {hi, lo}
                alu_a = zext_m(r_hi);
                alu_b = r_lo[0] ? zext_m(r_mcand) : '0;
                n_hi  = alu.sum[MW:1];
                n_lo  = {alu.sum[0], r_lo[MW-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MW - 1)) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                // upper half not below divisor: quotient too big for any result
                alu_a   = zext_m(r_hi);
                alu_b   = zext_m(r_div);
                alu_sub = 1'b1;
                if (!alu.neg) begin
                    n_ovf   = 1'b1;
                    n_state = S_ADD;
                end else begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                alu_a   = {{(AW-MW-1){1'b0}}, r_hi, r_lo[MW-1]};
                alu_b   = zext_m(r_div);
                alu_sub = 1'b1;
                if (!alu.neg) begin
                    n_hi = alu.sum[MW-1:0];
                end else begin
                    n_hi = {r_hi[MW-2:0], r_lo[MW-1]};
                end
                n_lo  = {r_lo[MW-2:0], ~alu.neg};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MW - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                alu_a   = sext_v(r_y0);
                alu_b   = zext_m(r_lo);
                alu_sub = r_neg;
                if (r_ovf) begin
                    n_res = r_neg ? V_MIN : V_MAX;
                end else if ((&alu.sum[AW-1:VW-1]) || !(|alu.sum[AW-1:VW-1])) begin
                    n_res = alu.sum[VW-1:0];
                end else begin
                    n_res = alu.sum[AW-1] ? V_MIN : V_MAX;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out_data.y_result   = r_res;
                    n_out_data.range_flag = r_flag;
                    n_out_data.zero_width = r_zw;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_last     <= n_last;
        r_i        <= n_i;
        r_s        <= n_s;
        r_flag     <= n_flag;
        r_x0       <= n_x0;
        r_y0       <= n_y0;
        r_x1       <= n_x1;
        r_y1       <= n_y1;
        r_dsel     <= n_dsel;
        r_acc      <= n_acc;
        r_neg      <= n_neg;
        r_div      <= n_div;
        r_mcand    <= n_mcand;
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_cnt      <= n_cnt;
        r_ovf      <= n_ovf;
        r_res      <= n_res;
        r_zw       <= n_zw;
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= POINT_COUNT_RST;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_point_count <= n_point_count;
        end
    end

endmodule

FILE: verif/tb_piecewise_linear_interpolator.sv
`timescale 1ns / 100ps

module tb_piecewise_linear_interpolator;
    import pli_pkg::*;

    localparam int     N_PTS    = 64;
    localparam int     TAIL_CYC = 200;
    localparam int     N_ITEMS  = 1250;
    localparam longint ONE      = 64'sd65536;               // 1.0 in Q16
    localparam longint V_HI     = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint V_LO     = -(64'sd1 <<< (VW - 1));

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    piecewise_linear_interpolator #(.MAX_POINTS(N_PTS)) dut (.*);

    // breakpoint table and count as the block should hold them
    logic signed [VW-1:0] bp_x [N_PTS];
    logic signed [VW-1:0] bp_y [N_PTS];
    logic [CFG_W-1:0]     point_count;
    t_out_item            pending_results[$];

    int n_errors;
    int n_loads;
    int n_evals;
    int n_below;
    int n_above;
    int n_zero_w;
    int n_cfg;
    bit no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("ERROR: %s", msg);
    endtask

    function automatic int eff_count(input logic [CFG_W-1:0] c);
        int n;
        n = int'(c);
        if (n < 2) n = 2;
        if (n > N_PTS) n = N_PTS;
        return n;
    endfunction

    function automatic t_out_item lookup_expected(input t_in_item it);
        t_out_item           res;
        int                  n;
        int                  seg;
        int                  i;
        bit                  found;
        logic signed [127:0] qx;
        logic signed [127:0] x0;
        logic signed [127:0] x1;
        logic signed [127:0] y0;
        logic signed [127:0] y1;
        logic signed [127:0] sum;
        res = '0;
        if (it.op == OP_LOAD) return res;
        n  = eff_count(point_count);
        qx = $signed(it.x_value);
        if (qx < bp_x[0]) begin
            seg = 0;
            res.range_flag = RANGE_BELOW;
        end else if (qx > bp_x[n-1]) begin
            seg = n - 2;
            res.range_flag = RANGE_ABOVE;
        end else begin
            // first segment whose right end is at or above x
            seg   = n - 2;
            found = 1'b0;
            for (i = 0; i < n - 1; i++) begin
                if (!found && bp_x[i+1] >= qx) begin
                    seg   = i;
                    found = 1'b1;
                end
            end
        end
        x0 = bp_x[seg];
        x1 = bp_x[seg+1];
        y0 = bp_y[seg];
        y1 = bp_y[seg+1];
        if (x1 == x0) begin
            res.zero_width = 1'b1;
            res.y_result   = y0[VW-1:0];
        end else begin
            // signed divide truncates toward zero; product is exact at 128 bits
            sum = y0 + ((y1 - y0) * (qx - x0)) / (x1 - x0);
            if (sum > $signed(V_MAX))
                res.y_result = V_MAX;
            else if (sum < $signed(V_MIN))
                res.y_result = V_MIN;
            else
                res.y_result = sum[VW-1:0];
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic longint rand_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return longint'($signed(r[VW-1:0]));
    endfunction

    function automatic longint clamp48(input longint v);
        if (v > V_HI) return V_HI;
        if (v < V_LO) return V_LO;
        return v;
    endfunction

    function automatic longint pick_y();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return rand_value() >>> $urandom_range(8, 30);
        if (r < 80) return rand_value();
        case ($urandom_range(0, 2))
            0:       return V_HI;
            1:       return V_LO;
            default: return 0;
        endcase
    endfunction

    function automatic longint pick_query(input int n);
        int          r;
        int          s;
        longint      lo;
        longint      hi;
        longint      t;
        logic [63:0] r64;
        r   = $urandom_range(0, 99);
        r64 = {$urandom, $urandom};
        if (r < 55) begin
            s  = $urandom_range(0, n - 2);
            lo = bp_x[s];
            hi = bp_x[s+1];
            if (lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            return lo + longint'(r64 % 64'(hi - lo + 1));
        end
        if (r < 65) return bp_x[$urandom_range(0, n - 1)];
        if (r < 75) return clamp48(longint'(bp_x[0]) - longint'(r64[23:0]) - 1);
        if (r < 85) return clamp48(longint'(bp_x[n-1]) + longint'(r64[23:0]) + 1);
        return rand_value();
    endfunction

    // valid stays high across back-to-back beats; dropped during a gap or by wait_drained
    task automatic send_item(input t_in_item it);
        t_out_item want;
        int        gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        want = lookup_expected(it);
        pending_results.push_back(want);
        if (it.op == OP_LOAD) begin
            bp_x[it.point_index] = it.x_value;
            bp_y[it.point_index] = it.y_value;
            n_loads++;
        end else begin
            n_evals++;
            if (want.range_flag == RANGE_BELOW) n_below++;
            if (want.range_flag == RANGE_ABOVE) n_above++;
            if (want.zero_width) n_zero_w++;
        end
    endtask

    task automatic send_load(input int idx, input longint xv, input longint yv);
        t_in_item it;
        it.op          = OP_LOAD;
        it.point_index = IDX_W'(idx);
        it.x_value     = xv[VW-1:0];
        it.y_value     = yv[VW-1:0];
        send_item(it);
    endtask

    task automatic send_eval(input longint xv);
        t_in_item it;
        longint   junk;
        junk           = rand_value();
        it.op          = OP_EVAL;
        it.point_index = IDX_W'($urandom_range(0, N_PTS - 1));
        it.x_value     = xv[VW-1:0];
        it.y_value     = junk[VW-1:0];
        send_item(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [CFG_W-1:0] value);
        logic [PDATA_W-1:0] got;
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_POINT_COUNT, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        point_count = value;
        n_cfg++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // read back
        @(negedge i_clk);
        psel    <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== PDATA_W'(point_count))
            flag_error($sformatf("point_count readback exp %0d got %h", point_count, got));
    endtask

    // sorted table with random spacing (duplicates now and then), or full-range noise
    task automatic build_table(input int n);
        int     mode;
        int     sh;
        int     i;
        longint xv;
        longint incr;
        mode = $urandom_range(0, 99);
        sh   = ($urandom_range(0, 9) < 7) ? $urandom_range(4, 24) : $urandom_range(25, 40);
        xv   = rand_value() >>> $urandom_range(10, 47);
        for (i = 0; i < n; i++) begin
            if (mode < 85) begin
                if (i > 0) begin
                    incr = ($urandom_range(0, 15) == 0) ? 0 :
                           (rand_value() & ((64'sd1 <<< sh) - 1));
                    xv   = xv + incr;
                end
            end else begin
                xv = rand_value();
            end
            send_load(i, xv, pick_y());
        end
    endtask

    task automatic test_directed_cases();
        set_count(CFG_W'(3));
        // ordinary table, steep last segment
        send_load(0, -2 * ONE, -(15 * ONE) / 2);
        send_load(1, ONE, 3 * ONE);
        send_load(2, 3 * ONE, V_HI);
        send_eval(-2 * ONE);   // exactly the first point
        send_eval(V_LO);       // far below, saturates low
        send_eval(V_HI);       // far above, saturates high
        send_eval(ONE / 4);
        send_eval(3 * ONE);    // exactly the last point
        // every segment has zero width
        send_load(0, ONE, 2 * ONE);
        send_load(1, ONE, 9 * ONE);
        send_load(2, ONE, -4 * ONE);
        send_eval(ONE);
        send_eval(0);
        send_eval(5 * ONE);
        // unsorted table at the value extremes
        send_load(0, V_HI, V_LO);
        send_load(1, V_LO, V_HI);
        send_load(2, 0, 0);
        send_eval(0);
        send_eval(V_HI);
    endtask

    task automatic test_full_table();
        set_count(CFG_W'(N_PTS));
        build_table(N_PTS);
        no_idle = 1'b1;
        repeat (60) send_eval(pick_query(N_PTS));
        no_idle = 1'b0;
        wait_drained();   // hold off the sender until every result is back
        repeat (90) send_eval(pick_query(N_PTS));
    endtask

    // register values outside 2..64 are clamped by the block
    task automatic test_count_clamp();
        int vals[4];
        int k;
        vals = '{0, 1, 65, 127};
        for (k = 0; k < 4; k++) begin
            set_count(CFG_W'(vals[k]));
            repeat (8) send_eval(pick_query(eff_count(point_count)));
        end
    endtask

    task automatic test_random_tables(input int target);
        int               phase;
        int               r;
        int               n;
        int               i;
        int               q;
        logic [CFG_W-1:0] cnt;
        phase = 0;
        while (n_loads + n_evals < target) begin
            r = $urandom_range(0, 99);
            if (phase == 0)
                cnt = CFG_W'(2);
            else if (phase == 1)
                cnt = CFG_W'(N_PTS);
            else if (r < 60)
                cnt = CFG_W'($urandom_range(2, 12));
            else if (r < 90)
                cnt = CFG_W'($urandom_range(13, N_PTS));
            else if (r < 95)
                cnt = CFG_W'($urandom_range(0, 1));
            else
                cnt = CFG_W'($urandom_range(N_PTS + 1, 127));
            set_count(cnt);
            n = eff_count(cnt);
            no_idle = (phase == 3);
            build_table(n);
            if ($urandom_range(0, 9) == 0 && n < N_PTS)
                repeat ($urandom_range(1, 3))
                    send_load($urandom_range(n, N_PTS - 1), rand_value(), rand_value());
            q = $urandom_range(10, 40);
            for (i = 0; i < q; i++) begin
                if ($urandom_range(0, 49) == 0) wait_drained();
                send_eval(pick_query(n));
            end
            no_idle = 1'b0;
            phase++;
        end
    endtask

    initial begin : out_stall
        int hold;
        int gap;
        i_out_ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                gap = pick_gap();
                if (i_out_ready && gap > 0) begin
                    i_out_ready <= 1'b0;
                    hold = gap - 1;
                end else begin
                    i_out_ready <= 1'b1;
                    hold = $urandom_range(0, 30);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result beat with nothing pending: y=%h flag=%0d zw=%0b",
                                     o_out_data.y_result, o_out_data.range_flag,
                                     o_out_data.zero_width));
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.y_result !== want.y_result ||
                    o_out_data.range_flag !== want.range_flag ||
                    o_out_data.zero_width !== want.zero_width)
                    flag_error($sformatf("y exp %h got %h, flag exp %0d got %0d, zw exp %0b got %0b",
                                         want.y_result, o_out_data.y_result,
                                         want.range_flag, o_out_data.range_flag,
                                         want.zero_width, o_out_data.zero_width));
            end
        end
    end

    initial begin
        int waited;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        point_count = POINT_COUNT_RST;
        no_idle     = 1'b0;
        n_errors    = 0;
        n_loads     = 0;
        n_evals     = 0;
        n_below     = 0;
        n_above     = 0;
        n_zero_w    = 0;
        n_cfg       = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_full_table();
        test_count_clamp();
        test_random_tables(N_ITEMS);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYC) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d loads, %0d lookups (%0d below range, %0d above, %0d zero-width)",
                 n_loads, n_evals, n_below, n_above, n_zero_w);
        $display("%0d point_count writes incl. clamped values; %0d errors", n_cfg, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
